### hdl/gdo_pkg.sv
// ----------------------------------------------------------------------------
// gdo_pkg
// Types, constants and calendar helpers shared by the date offset unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdo_pkg;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [8:0] MOD400_LAST = 9'd399;
    localparam logic       ACT_ADD = 1'b0;
    localparam logic       ACT_SUB = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [15:0] start_year;
        logic [15:0] day_count;
    } t_req;

    typedef struct packed {
        logic [3:0]  end_month;
        logic [4:0]  end_day;
        logic [15:0] end_year;
        logic        range_error;
        logic        bad_input;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic walk;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reduce_done;
        logic bad_now;
        logic cnt_zero;
    } t_dp_status;

    // Leap year from the year's residue modulo 400.
    function automatic logic f_is_leap(input logic [8:0] m400);
        logic cent;
        begin
            cent = (m400 == 9'd0) || (m400 == 9'd100) || (m400 == 9'd200)
                || (m400 == 9'd300);
            f_is_leap = (m400 == 9'd0) || ((m400[1:0] == 2'b00) && !cent);
        end
    endfunction

    // Month length; zero for a month code outside the calendar.
    function automatic logic [4:0] f_days_in(input logic [3:0] m, input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: f_days_in = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    f_days_in = 5'd30;
            MONTH_FEB:                                  f_days_in = leap ? 5'd29 : 5'd28;
            default:                                    f_days_in = 5'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### hdl/gdo_ctrl.sv
// ----------------------------------------------------------------------------
// gdo_ctrl
// Sequencer: load, residue reduction, date check, month walk, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_ctrl
    import gdo_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            busy,
    output logic            o_strobe
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_CHECK  = 5'b00100,
        S_WALK   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_REDUCE;
            end
            S_REDUCE: begin
                if (i_status.reduce_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.bad_now || i_status.cnt_zero) n_state = S_DONE;
                else n_state = S_WALK;
            end
            S_WALK: begin
                if (i_status.cnt_zero) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.reduce = (r_state == S_REDUCE);
        o_cmd.check  = (r_state == S_CHECK);
        o_cmd.walk   = (r_state == S_WALK) && !i_status.cnt_zero;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule

`default_nettype wire

### hdl/gdo_dpath.sv
// ----------------------------------------------------------------------------
// gdo_dpath
// Date registers, year residue reduction and the one-month step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_dpath
    import gdo_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int YEAR_BITS  = 16
) (
    input  wire logic   i_clk,
    input  wire t_req   i_req,
    input  wire t_dp_cmd i_cmd,
    output t_dp_status  o_status,
    output t_result     o_result
);

    localparam int YX = (YEAR_BITS > 16) ? YEAR_BITS : 16;
    localparam int CX = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int SW = $clog2(YEAR_BITS - 6);
    localparam int RW = YEAR_BITS + 2;
    localparam logic [SW-1:0] SHIFT_TOP = SW'(YEAR_BITS - 8);
    localparam logic [8:0] YMASK_MOD = 9'(((2 ** YEAR_BITS) - 1) % 400);
    localparam logic [YEAR_BITS-1:0] YMAX = '1;

    logic                  r_sub;
    logic [3:0]            r_month;
    logic [4:0]            r_day;
    logic [YEAR_BITS-1:0]  r_year;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [YEAR_BITS-1:0]  r_rem;
    logic [SW-1:0]         r_shift;
    logic                  r_range;
    logic                  r_bad;

    logic [YX-1:0] w_year_in;
    logic [CX-1:0] w_cnt_in;
    logic [YX-1:0] w_year_out;

    assign w_year_in = YX'(i_req.start_year);
    assign w_cnt_in  = CX'(i_req.day_count);
    assign w_year_out = YX'(r_year);

    // restoring reduction of the year modulo 400
    logic [RW-1:0] w_thr;
    logic          w_take;
    assign w_thr  = RW'(400) << r_shift;
    assign w_take = RW'(r_rem) >= w_thr;

    logic [8:0] w_m400;
    assign w_m400 = 9'(r_rem);

    // date check on the loaded start date
    logic [4:0] w_dim;
    assign w_dim = f_days_in(r_month, f_is_leap(w_m400));

    // one month step
    logic [4:0]            w_room;
    logic                  w_fwd_fit, w_bwd_fit;
    logic [3:0]            w_month_nx;
    logic [YEAR_BITS-1:0]  w_year_nx;
    logic [8:0]            w_m400_nx;
    logic                  w_range_nx;
    logic [4:0]            w_day_nx;
    logic [COUNT_BITS-1:0] w_cnt_nx;

    assign w_room    = w_dim - r_day;
    assign w_fwd_fit = r_cnt <= COUNT_BITS'(w_room);
    assign w_bwd_fit = r_cnt < COUNT_BITS'(r_day);

    always_comb begin
        w_month_nx = r_month;
        w_year_nx  = r_year;
        w_m400_nx  = w_m400;
        w_range_nx = r_range;
        w_day_nx   = r_day;
        w_cnt_nx   = r_cnt;
        if (r_sub == ACT_ADD) begin
            if (w_fwd_fit) begin
                w_day_nx = r_day + r_cnt[4:0];
                w_cnt_nx = '0;
            end else begin
                w_cnt_nx = r_cnt - (COUNT_BITS'(w_room) + COUNT_BITS'(1));
                w_day_nx = 5'd1;
                if (r_month < MONTH_DEC) begin
                    w_month_nx = r_month + 4'd1;
                end else begin
                    w_month_nx = MONTH_JAN;
                    if (r_year == YMAX) begin
                        w_range_nx = 1'b1;
                        w_year_nx  = '0;
                        w_m400_nx  = 9'd0;
                    end else begin
                        w_year_nx = r_year + YEAR_BITS'(1);
                        w_m400_nx = (w_m400 == MOD400_LAST) ? 9'd0 : w_m400 + 9'd1;
                    end
                end
            end
        end else begin
            if (w_bwd_fit) begin
                w_day_nx = r_day - r_cnt[4:0];
                w_cnt_nx = '0;
            end else begin
                w_cnt_nx = r_cnt - COUNT_BITS'(r_day);
                if (r_month > MONTH_JAN) begin
                    w_month_nx = r_month - 4'd1;
                end else begin
                    w_month_nx = MONTH_DEC;
                    if (r_year == '0) begin
                        w_range_nx = 1'b1;
                        w_year_nx  = YMAX;
                        w_m400_nx  = YMASK_MOD;
                    end else begin
                        w_year_nx = r_year - YEAR_BITS'(1);
                        w_m400_nx = (w_m400 == 9'd0) ? MOD400_LAST : w_m400 - 9'd1;
                    end
                end
                w_day_nx = f_days_in(w_month_nx, f_is_leap(w_m400_nx));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sub   <= i_req.action;
            r_month <= i_req.start_month;
            r_day   <= i_req.start_day;
            r_year  <= w_year_in[YEAR_BITS-1:0];
            r_rem   <= w_year_in[YEAR_BITS-1:0];
            r_cnt   <= w_cnt_in[COUNT_BITS-1:0];
            r_shift <= SHIFT_TOP;
            r_range <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_cmd.reduce) begin
            if (w_take) r_rem <= YEAR_BITS'(RW'(r_rem) - w_thr);
            if (r_shift != '0) r_shift <= r_shift - SW'(1);
        end else if (i_cmd.check) begin
            r_bad <= o_status.bad_now;
        end else if (i_cmd.walk) begin
            r_month <= w_month_nx;
            r_day   <= w_day_nx;
            r_year  <= w_year_nx;
            r_rem   <= YEAR_BITS'(w_m400_nx);
            r_cnt   <= w_cnt_nx;
            r_range <= w_range_nx;
        end
    end

    always_comb begin
        o_status.reduce_done = (r_shift == '0);
        o_status.bad_now     = (w_dim == 5'd0) || (r_day == 5'd0) || (r_day > w_dim);
        o_status.cnt_zero    = (r_cnt == '0);
    end

    always_comb begin
        o_result.end_month   = r_month;
        o_result.end_day     = r_day;
        o_result.end_year    = w_year_out[15:0];
        o_result.range_error = r_range;
        o_result.bad_input   = r_bad;
    end

endmodule

`default_nettype wire

### hdl/gregorian_date_offset_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset_unit
// Moves a Gregorian date forward or backward by a number of days.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on i_req and raise start while busy is low; the request
//   is taken at that clock edge and busy rises on the next cycle.
//   The result is flagged on o_result by o_strobe for exactly one cycle;
//   busy drops the cycle after. The receiver cannot stall: capture it then.
// Sequence per request, from the point at which start is taken:
//   a load, a reduction of the year modulo 400, a date check, the month
//   walk and a result strobe. The walk steps across each month crossed,
//   finishes inside the last month when the count ends there, and then
//   sees the count reach zero. A 65535-day move crosses about 2154 months
//   at the default widths. An invalid start date or a zero count skips
//   the walk.
// Requests are handled one at a time; a new request is taken once busy falls.
// Reset (synchronous, active low) returns the sequencer to idle; no result
// is pending afterward.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_offset_unit
    import gdo_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int YEAR_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_strobe,
    output t_result   o_result
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequence the request
    gdo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // hold the date and step it one month per cycle during the month walk
    gdo_dpath #(
        .COUNT_BITS (COUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### bench/date_shift_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_shift_checker
// Watches the request and result channels of the date offset unit. Computes
// the shifted date for each accepted request and compares every strobed
// result against the oldest outstanding date.
// ----------------------------------------------------------------------------

module date_shift_checker
    import gdo_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_req i_req,
    input  wire logic i_strobe,
    input  wire t_result i_result,
    output int        o_pending,
    output int        o_fail_count
);

    localparam int unsigned YEAR_MASK = 32'h0000_FFFF;

    t_result expected_dates[$];
    int      fail_count = 0;
    int      pending = 0;

    assign o_pending    = pending;
    assign o_fail_count = fail_count;

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            MONTH_FEB:             return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Walk the calendar one month per step, like the unit does.
    function automatic t_result shift_date(input t_req r);
        t_result     res;
        int unsigned m, d, y, n, dim, room;
        m = r.start_month;
        d = r.start_day;
        y = r.start_year;
        n = r.day_count;
        res = '0;
        dim = month_days(m, y);
        if (dim == 0 || d < 1 || d > dim) begin
            res.bad_input = 1'b1;
        end else if (r.action == ACT_ADD) begin
            while (n > 0) begin
                room = month_days(m, y) - d;
                if (n <= room) begin
                    d += n;
                    n = 0;
                end else begin
                    n -= room + 1;
                    d = 1;
                    if (m < MONTH_DEC) begin
                        m++;
                    end else begin
                        m = MONTH_JAN;
                        if (y == YEAR_MASK) res.range_error = 1'b1;
                        y = (y + 1) & YEAR_MASK;
                    end
                end
            end
        end else begin
            while (n > 0) begin
                if (n < d) begin
                    d -= n;
                    n = 0;
                end else begin
                    n -= d;
                    if (m > MONTH_JAN) begin
                        m--;
                    end else begin
                        m = MONTH_DEC;
                        if (y == 0) res.range_error = 1'b1;
                        y = (y - 1) & YEAR_MASK;
                    end
                    d = month_days(m, y);
                end
            end
        end
        res.end_month = m[3:0];
        res.end_day   = d[4:0];
        res.end_year  = y[15:0];
        return res;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_start && !i_busy) expected_dates.push_back(shift_date(i_req));
            if (i_strobe) begin
                if (expected_dates.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("end_month", want.end_month, i_result.end_month);
                    check_field("end_day", want.end_day, i_result.end_day);
                    check_field("end_year", want.end_year, i_result.end_year);
                    check_field("range_error", want.range_error, i_result.range_error);
                    check_field("bad_input", want.bad_input, i_result.bad_input);
                end
            end
            pending <= expected_dates.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the Gregorian date offset unit. A directed pass covers
// leap and century Februaries, year wrap at both ends and invalid dates;
// a random pass follows. The checker beside the unit scores every result.
// ----------------------------------------------------------------------------

module tb;
    import gdo_pkg::*;

    localparam int RANDOM_REQUESTS = 270;
    localparam int SETTLE_CYCLES   = 20;
    // Slowest run: every request a full 65535-day walk plus sender gaps;
    // take that several times over.
    localparam int CYCLE_LIMIT     = 2_000_000;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    t_req    req;
    logic    busy;
    logic    strobe;
    t_result result;
    int      pending;
    int      failures;
    int      cycles = 0;
    bit      gaps_on = 1'b1;

    always #4 clk = ~clk;

    gregorian_date_offset_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_req    (req),
        .busy     (busy),
        .o_strobe (strobe),
        .o_result (result)
    );

    date_shift_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_pending    (pending),
        .o_fail_count (failures)
    );

    // Abort a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_req date_req(input logic act, input int unsigned m,
                                      input int unsigned d, input int unsigned y,
                                      input int unsigned n);
        t_req r;
        r.action      = act;
        r.start_month = m[3:0];
        r.start_day   = d[4:0];
        r.start_year  = y[15:0];
        r.day_count   = n[15:0];
        return r;
    endfunction

    // Bias years toward the wrap points and the century leap rules.
    function automatic int unsigned pick_year();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom_range(0, 65535);
        if (sel < 6) return $urandom_range(0, 3);
        if (sel < 7) return $urandom_range(65530, 65535);
        if (sel < 8) return $urandom_range(0, 163) * 400 + $urandom_range(0, 2);
        return $urandom_range(0, 655) * 100 + $urandom_range(0, 4);
    endfunction

    // Mostly small moves; a few span the whole count range.
    function automatic int unsigned pick_count();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)  return 0;
        if (sel < 45) return $urandom_range(1, 40);
        if (sel < 70) return $urandom_range(1, 400);
        if (sel < 88) return $urandom_range(1, 4000);
        if (sel < 97) return $urandom_range(0, 65535);
        return 65535;
    endfunction

    function automatic t_req random_request();
        int unsigned sel, m, d;
        sel = $urandom_range(0, 99);
        m = $urandom_range(1, 12);
        // Favor month ends so that moves cross boundaries early.
        d = ($urandom_range(0, 9) < 3) ? $urandom_range(27, 31) : $urandom_range(1, 31);
        // Break the date in a minority of requests.
        if (sel < 5) begin
            m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
            d = $urandom_range(0, 31);
        end else if (sel < 9) begin
            d = 0;
        end
        return date_req($urandom_range(0, 1), m, d, pick_year(), pick_count());
    endfunction

    // Offer one request and hold it until the unit takes it.
    task automatic post_request(input t_req r);
        logic [63:0] junk;
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            do begin
                junk = {$urandom(), $urandom()};
                req <= junk[$bits(t_req)-1:0];
                @(posedge clk);
            end while ($urandom_range(0, 99) < 50);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and hold off until every result is back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        start <= 1'b0;
        req   <= '0;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero count returns the start date.
        post_request(date_req(ACT_ADD, 1, 1, 2000, 0));
        post_request(date_req(ACT_SUB, 7, 15, 1999, 0));
        // Century and leap Februaries, both directions.
        post_request(date_req(ACT_ADD, 2, 28, 1900, 1));
        post_request(date_req(ACT_ADD, 2, 28, 2000, 1));
        post_request(date_req(ACT_ADD, 2, 28, 2024, 1));
        post_request(date_req(ACT_SUB, 3, 1, 2000, 1));
        post_request(date_req(ACT_SUB, 3, 1, 1900, 1));
        // Year wrap at the top and bottom; year 0 counts as leap.
        post_request(date_req(ACT_ADD, 12, 31, 65535, 1));
        post_request(date_req(ACT_SUB, 1, 1, 0, 1));
        post_request(date_req(ACT_ADD, 12, 31, 65535, 60));
        // Longest walks.
        post_request(date_req(ACT_ADD, 1, 1, 0, 65535));
        post_request(date_req(ACT_SUB, 12, 31, 65535, 65535));
        post_request(date_req(ACT_SUB, 1, 1, 0, 65535));
        post_request(date_req(ACT_ADD, 12, 31, 65535, 65535));
        // Invalid start dates echo the input.
        post_request(date_req(ACT_ADD, 2, 29, 2023, 5));
        post_request(date_req(ACT_ADD, 0, 10, 2020, 5));
        post_request(date_req(ACT_SUB, 13, 1, 2020, 5));
        post_request(date_req(ACT_ADD, 15, 31, 65535, 65535));
        post_request(date_req(ACT_SUB, 4, 31, 2021, 3));
        post_request(date_req(ACT_ADD, 6, 0, 2021, 3));
        // Full-length months and multi-year spans.
        post_request(date_req(ACT_ADD, 1, 31, 2021, 31));
        post_request(date_req(ACT_SUB, 2, 29, 2400, 365));
        post_request(date_req(ACT_ADD, 11, 30, 2099, 400));
        drain();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // Run a back-to-back stretch in the middle.
            gaps_on = !(i >= 100 && i < 160);
            if (i == 200) drain();
            post_request(random_request());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
